// ===== sv/bid_pkg.sv =====
// Shared types, codes and ring-slot arithmetic for the bounded identifier deque.
package bid_pkg;

   localparam int CAPACITY = 64;
   localparam int ID_BITS  = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   typedef logic [ID_BITS-1:0] id_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [2:0]         op_type;
   typedef logic [1:0]         status_type;
   typedef logic [1:0]         rsel_type;

   // command codes
   localparam op_type OP_PUSH_FRONT = 3'd0;
   localparam op_type OP_PUSH_BACK  = 3'd1;
   localparam op_type OP_POP_FRONT  = 3'd2;
   localparam op_type OP_POP_BACK   = 3'd3;
   localparam op_type OP_SEARCH     = 3'd4;
   localparam op_type OP_DELETE     = 3'd5;

   // status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EMPTY     = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_NOT_FOUND = 2'd3;

   // read address select
   localparam rsel_type RSEL_HEAD = 2'd0;
   localparam rsel_type RSEL_NEXT = 2'd1;
   localparam rsel_type RSEL_SKIP = 2'd2;
   localparam rsel_type RSEL_BACK = 2'd3;

   typedef struct packed {
      logic       latch;
      logic       stat_set;
      status_type stat_code;
      logic       push_front;
      logic       push_back;
      logic       pop_front;
      logic       dec_count;
      logic       pos_clear;
      logic       pos_inc;
      logic       shift_wr;
      rsel_type   rd_sel;
      logic       cap_front;
      logic       cap_back;
      logic       clr_ends;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   match;
      logic   more1;
      logic   more2;
   } dp_stat_type;

   localparam logic [IDX_W:0] CAP_EXT = (IDX_W + 1)'(CAPACITY);

   // physical slot of a logical position, wrapped once around the ring
   function automatic idx_type slot_of(input idx_type head, input idx_type off);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= CAP_EXT) begin
         sum = sum - CAP_EXT;
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== sv/bid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bid_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bid_dp.sv =====
// Datapath: ring pointers, entry count, walk position, ring RAM and result registers.
module bid_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bid_pkg::dp_cmd_type  cmd,
   output bid_pkg::dp_stat_type stat,
   input  bid_pkg::op_type      req_cmd,
   input  bid_pkg::id_type      req_id_value,
   output bid_pkg::status_type  rsp_status,
   output bid_pkg::cnt_type     rsp_entry_count,
   output bid_pkg::id_type      rsp_front_id,
   output bid_pkg::id_type      rsp_back_id
);
   import bid_pkg::*;

   idx_type    head_ff, head_in;
   cnt_type    count_ff, count_in;
   idx_type    pos_ff, pos_in;
   op_type     op_ff;
   id_type     id_ff;
   status_type status_ff;
   id_type     front_ff, back_ff;

   logic       wr_en;
   idx_type    wr_addr, rd_addr, head_m1;
   id_type     wr_data, rd_data;
   logic [CNT_W:0] pos_ext;

   assign head_m1 = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - 1'b1;
   assign pos_ext = (CNT_W + 1)'(pos_ff);

   always_comb begin
      head_in = head_ff;
      if (cmd.push_front) begin
         head_in = head_m1;
      end else if (cmd.pop_front) begin
         head_in = slot_of(head_ff, IDX_W'(1));
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push_front || cmd.push_back) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop_front || cmd.dec_count) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_clear) begin
         pos_in = '0;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.latch) begin
         op_ff     <= req_cmd;
         id_ff     <= req_id_value;
         status_ff <= ST_OK;
      end else if (cmd.stat_set) begin
         status_ff <= cmd.stat_code;
      end
      if (cmd.clr_ends) begin
         front_ff <= '0;
         back_ff  <= '0;
      end else begin
         if (cmd.cap_front) begin
            front_ff <= rd_data;
         end
         if (cmd.cap_back) begin
            back_ff <= rd_data;
         end
      end
   end

   // write port: pushes store the request value, the delete shift moves entries down
   always_comb begin
      wr_en   = cmd.push_front || cmd.push_back || cmd.shift_wr;
      wr_data = cmd.shift_wr ? rd_data : id_ff;
      if (cmd.push_front) begin
         wr_addr = head_m1;
      end else if (cmd.push_back) begin
         wr_addr = slot_of(head_ff, count_ff[IDX_W-1:0]);
      end else begin
         wr_addr = slot_of(head_ff, pos_ff);
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RSEL_HEAD: rd_addr = head_ff;
         RSEL_NEXT: rd_addr = slot_of(head_ff, pos_ff + IDX_W'(1));
         RSEL_SKIP: rd_addr = slot_of(head_ff, pos_ff + IDX_W'(2));
         RSEL_BACK: rd_addr = slot_of(head_ff, IDX_W'(count_ff - 1'b1));
         default:   rd_addr = head_ff;
      endcase
   end

   bid_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (CAPACITY)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.op    = op_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(CAPACITY));
   assign stat.match = (rd_data == id_ff);
   assign stat.more1 = (pos_ext + (CNT_W + 1)'(1)) < {1'b0, count_ff};
   assign stat.more2 = (pos_ext + (CNT_W + 1)'(2)) < {1'b0, count_ff};

   assign rsp_status      = status_ff;
   assign rsp_entry_count = count_ff;
   assign rsp_front_id    = front_ff;
   assign rsp_back_id     = back_ff;

endmodule

// ===== sv/bid_ctrl.sv =====
// Controller state machine: sequences commands, the search walk and the delete shift.
module bid_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   input  bid_pkg::dp_stat_type stat,
   output bid_pkg::dp_cmd_type  cmd
);
   import bid_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_RD_B  = 3'd5;
   localparam logic [2:0] S_CAP_B = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd      = '0;
      cmd.rd_sel = RSEL_HEAD;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FIN;
            case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.stat_set  = 1'b1;
                     cmd.stat_code = ST_FULL;
                  end else if (stat.op == OP_PUSH_FRONT) begin
                     cmd.push_front = 1'b1;
                  end else begin
                     cmd.push_back = 1'b1;
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.stat_set  = 1'b1;
                     cmd.stat_code = ST_EMPTY;
                  end else if (stat.op == OP_POP_FRONT) begin
                     cmd.pop_front = 1'b1;
                  end else begin
                     cmd.dec_count = 1'b1;
                  end
               end
               OP_SEARCH, OP_DELETE: begin
                  if (stat.empty) begin
                     cmd.stat_set  = 1'b1;
                     cmd.stat_code = ST_NOT_FOUND;
                  end else begin
                     cmd.pos_clear = 1'b1;
                     cmd.rd_sel    = RSEL_HEAD;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (stat.match) begin
               if (stat.op == OP_DELETE && stat.more1) begin
                  cmd.rd_sel = RSEL_NEXT;
                  state_in   = S_SHIFT;
               end else begin
                  cmd.dec_count = (stat.op == OP_DELETE);
                  state_in      = S_FIN;
               end
            end else if (stat.more1) begin
               cmd.pos_inc = 1'b1;
               cmd.rd_sel  = RSEL_NEXT;
            end else begin
               cmd.stat_set  = 1'b1;
               cmd.stat_code = ST_NOT_FOUND;
               state_in      = S_FIN;
            end
         end
         S_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (stat.more2) begin
               cmd.pos_inc = 1'b1;
               cmd.rd_sel  = RSEL_SKIP;
            end else begin
               cmd.dec_count = 1'b1;
               state_in      = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.empty) begin
               cmd.clr_ends = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmd.rd_sel = RSEL_HEAD;
               state_in   = S_RD_B;
            end
         end
         S_RD_B: begin
            cmd.cap_front = 1'b1;
            cmd.rd_sel    = RSEL_BACK;
            state_in      = S_CAP_B;
         end
         S_CAP_B: begin
            cmd.cap_back = 1'b1;
            valid_in     = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ===== sv/bounded_id_deque_top.sv =====
// Top level of the bounded identifier deque: controller plus datapath.
//
// A bounded double-ended queue of up to 64 sixteen-bit identifiers held in a
// ring RAM. A command transaction is taken at a rising edge where start is
// high and busy is low; exactly one result transaction follows, shown on the
// rsp_ ports for a single cycle while rsp_valid is high, and the receiver
// must take it in that cycle since nothing holds it. Every result carries a
// status (ok/found, empty on pop, full on push, not found), the entry count
// after the command and the identifiers at front and back (zero when empty).
// Pushes, pops and unused codes need no walk. Search walks the entries from
// the front until it finds a match or runs out of entries; a delete that
// hits walks to the match and then shifts every later entry down one place
// to close the gap. When the queue ends up empty, front and back are not
// fetched. The single RAM read port sets the pace: the walk and the
// gap-closing shift use it one entry per cycle, and front and back are then
// fetched through the same port.
// Busy drops in the same cycle as rsp_valid, so a new command can be taken
// at the edge that ends the result cycle.
module bounded_id_deque_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bid_pkg::op_type     req_cmd,
   input  bid_pkg::id_type     req_id_value,
   output logic                rsp_valid,
   output bid_pkg::status_type rsp_status,
   output bid_pkg::cnt_type    rsp_entry_count,
   output bid_pkg::id_type     rsp_front_id,
   output bid_pkg::id_type     rsp_back_id
);
   import bid_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequence the command; drive the datapath one step per cycle
   bid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // hold pointers, ring store and the registered result fields
   bid_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .stat            (dp_stat),
      .req_cmd         (req_cmd),
      .req_id_value    (req_id_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_front_id    (rsp_front_id),
      .rsp_back_id     (rsp_back_id)
   );

endmodule

// ===== sv/bid_chk.sv =====
// Port-level checker for the bounded identifier deque, bound to the top level.
module bid_chk (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input bid_pkg::cnt_type    rsp_entry_count,
   input bid_pkg::id_type     rsp_front_id,
   input bid_pkg::id_type     rsp_back_id
);
   import bid_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("transaction ended without a result");

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_count == '0 |-> rsp_front_id == '0 && rsp_back_id == '0)
      else $error("empty result with nonzero front or back");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

endmodule

bind bounded_id_deque_top bid_chk u_bid_chk (.*);

// ===== tb/sv/bounded_id_deque_top_test.sv =====
// Self-checking testbench for the bounded identifier deque: queued commands, predictor, monitor.
`timescale 1ns / 1ps

module bounded_id_deque_top_test;
   import bid_pkg::*;

   // Unused command codes; the block must leave its contents alone on these.
   localparam op_type OP_SPARE6 = 3'd6;
   localparam op_type OP_SPARE7 = 3'd7;

   localparam int RANDOM_ITEMS = 1690;
   localparam int DRAIN_CYCLES = 80;   // longer than the slowest command

   // One command transaction plus the idle gap the driver waits before it.
   typedef struct {
      op_type cmd;
      id_type id_value;
      int     gap;
   } deque_cmd_type;

   // What the block reports after one command.
   typedef struct {
      status_type status;
      cnt_type    count;
      id_type     front;
      id_type     back;
   } deque_view_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   op_type     req_cmd;
   id_type     req_id_value;
   logic       rsp_valid;
   status_type rsp_status;
   cnt_type    rsp_entry_count;
   id_type     rsp_front_id;
   id_type     rsp_back_id;

   deque_cmd_type  cmd_queue[$];
   deque_view_type expected_views[$];
   int             mismatch_count;

   // Predictor copy of the deque contents.
   id_type      ring_model[CAPACITY];
   idx_type     head_model;
   int unsigned held_model;

   // Driver staging state.
   deque_cmd_type staged_cmd;
   bit            have_staged;
   int            wait_left;

   bounded_id_deque_top uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_cmd(req_cmd),
      .req_id_value(req_id_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_front_id(rsp_front_id),
      .rsp_back_id(rsp_back_id)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Physical slot of a logical position counted from the front.
   function automatic idx_type slot_at(input int unsigned pos);
      return idx_type'((int'(head_model) + pos) % CAPACITY);
   endfunction

   // Apply one accepted command to the predictor copy and queue the view it should produce.
   function automatic void predict_deque(input op_type cmd, input id_type v);
      deque_view_type view;
      bit             hit;
      int unsigned    hit_pos;
      view.status = ST_OK;
      hit = 1'b0;
      hit_pos = 0;
      // walk from the front; only the first match counts
      if (cmd == OP_SEARCH || cmd == OP_DELETE) begin
         for (int unsigned i = 0; i < held_model; i++) begin
            if (!hit && ring_model[slot_at(i)] == v) begin
               hit = 1'b1;
               hit_pos = i;
            end
         end
      end
      case (cmd)
         OP_PUSH_FRONT: begin
            if (held_model >= CAPACITY) begin
               view.status = ST_FULL;
            end else begin
               head_model = idx_type'((int'(head_model) + CAPACITY - 1) % CAPACITY);
               ring_model[head_model] = v;
               held_model++;
            end
         end
         OP_PUSH_BACK: begin
            if (held_model >= CAPACITY) begin
               view.status = ST_FULL;
            end else begin
               ring_model[slot_at(held_model)] = v;
               held_model++;
            end
         end
         OP_POP_FRONT: begin
            if (held_model == 0) begin
               view.status = ST_EMPTY;
            end else begin
               head_model = slot_at(1);
               held_model--;
            end
         end
         OP_POP_BACK: begin
            if (held_model == 0) begin
               view.status = ST_EMPTY;
            end else begin
               held_model--;
            end
         end
         OP_SEARCH: begin
            if (!hit) begin
               view.status = ST_NOT_FOUND;
            end
         end
         OP_DELETE: begin
            if (!hit) begin
               view.status = ST_NOT_FOUND;
            end else begin
               // close the gap, keeping the order of the later entries
               for (int unsigned i = hit_pos; i + 1 < held_model; i++) begin
                  ring_model[slot_at(i)] = ring_model[slot_at(i + 1)];
               end
               held_model--;
            end
         end
         default: ;
      endcase
      view.count = cnt_type'(held_model);
      if (held_model == 0) begin
         view.front = '0;
         view.back  = '0;
      end else begin
         view.front = ring_model[slot_at(0)];
         view.back  = ring_model[slot_at(held_model - 1)];
      end
      expected_views.push_back(view);
   endfunction

   // Driver: take commands from the queue, hold each until the block accepts it.
   always @(posedge clock) begin
      if (reset) begin
         start        <= 1'b0;
         req_cmd      <= OP_PUSH_FRONT;
         req_id_value <= '0;
         have_staged  = 1'b0;
         wait_left    = 0;
         head_model   = '0;
         held_model   = 0;
      end else begin
         // a transaction moves on this edge: predict its result now
         if (start && !busy) begin
            predict_deque(req_cmd, req_id_value);
         end
         // channel is free unless a command is still waiting on busy
         if (!start || !busy) begin
            if (!have_staged && cmd_queue.size() > 0) begin
               staged_cmd  = cmd_queue.pop_front();
               have_staged = 1'b1;
               wait_left   = staged_cmd.gap;
            end
            if (have_staged && wait_left == 0) begin
               start        <= 1'b1;
               req_cmd      <= staged_cmd.cmd;
               req_id_value <= staged_cmd.id_value;
               have_staged  = 1'b0;
            end else begin
               if (have_staged) begin
                  wait_left--;
               end
               // idle: drop start and put noise on the payload
               start        <= 1'b0;
               req_cmd      <= op_type'($urandom_range(0, 7));
               req_id_value <= id_type'($urandom);
            end
         end
      end
   end

   // Monitor: every strobed result must match the oldest prediction.
   always @(posedge clock) begin
      deque_view_type want;
      if (!reset && rsp_valid) begin
         if (expected_views.size() == 0) begin
            $error("result with no command outstanding: status %0d count %0d",
                   rsp_status, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = expected_views.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, got %0d", want.count, rsp_entry_count);
               mismatch_count++;
            end
            if (rsp_front_id !== want.front) begin
               $error("front_id: expected %h, got %h", want.front, rsp_front_id);
               mismatch_count++;
            end
            if (rsp_back_id !== want.back) begin
               $error("back_id: expected %h, got %h", want.back, rsp_back_id);
               mismatch_count++;
            end
         end
      end
   end

   // Stimulus helpers ----------------------------------------------------------

   int  since_toggle;
   bit  calm_stretch;

   // Queue one command; draw its gap, with stretches where the sender never idles.
   task automatic add_cmd(input op_type cmd, input id_type v);
      deque_cmd_type c;
      since_toggle++;
      if (since_toggle >= 30) begin
         since_toggle = 0;
         calm_stretch = ($urandom_range(0, 3) == 0);
      end
      c.cmd      = cmd;
      c.id_value = v;
      c.gap      = calm_stretch ? 0 : $urandom_range(0, 6);
      cmd_queue.push_back(c);
   endtask

   // Half the time draw from a small pool so searches and deletes hit; otherwise anything.
   function automatic id_type pick_id();
      id_type pool[8];
      pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
               16'h1234, 16'h00FF, 16'hAAAA, 16'h5555};
      if ($urandom_range(0, 1) == 0) begin
         return pool[$urandom_range(0, 7)];
      end
      return id_type'($urandom);
   endfunction

   // Draw a command from weights: push, pop, search, delete, spare (percent).
   function automatic op_type pick_cmd(input int w_push, input int w_pop,
                                       input int w_search, input int w_del);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < w_push) begin
         return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end
      roll -= w_push;
      if (roll < w_pop) begin
         return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      roll -= w_pop;
      if (roll < w_search) begin
         return OP_SEARCH;
      end
      roll -= w_search;
      if (roll < w_del) begin
         return OP_DELETE;
      end
      return $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
   endfunction

   // Main sequence: build the command list, run reset, wait for everything to drain.
   initial begin
      int     made;
      int     phase;
      int     phase_len;
      op_type c;
      mismatch_count = 0;
      since_toggle   = 0;
      calm_stretch   = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = OP_PUSH_FRONT;
      req_id_value   = '0;

      // Directed: empty-queue cases, spare codes, field extremes, duplicates.
      add_cmd(OP_POP_FRONT, 16'h0000);
      add_cmd(OP_POP_BACK, 16'hFFFF);
      add_cmd(OP_SEARCH, 16'h0000);
      add_cmd(OP_DELETE, 16'h0000);
      add_cmd(OP_SPARE6, 16'h1111);
      add_cmd(OP_SPARE7, 16'hFFFF);
      add_cmd(OP_PUSH_FRONT, 16'hFFFF);
      add_cmd(OP_PUSH_BACK, 16'h0000);
      add_cmd(OP_PUSH_FRONT, 16'h8000);
      add_cmd(OP_PUSH_BACK, 16'h1234);
      add_cmd(OP_PUSH_BACK, 16'h1234);
      add_cmd(OP_PUSH_BACK, 16'h0001);
      add_cmd(OP_SEARCH, 16'h8000);
      add_cmd(OP_SEARCH, 16'h0001);
      add_cmd(OP_SEARCH, 16'h4321);
      add_cmd(OP_DELETE, 16'h1234);
      add_cmd(OP_DELETE, 16'h7777);
      add_cmd(OP_SPARE6, 16'h0000);
      add_cmd(OP_DELETE, 16'h8000);
      add_cmd(OP_DELETE, 16'h0001);
      add_cmd(OP_POP_FRONT, 16'hFFFF);
      add_cmd(OP_POP_BACK, 16'h0000);
      add_cmd(OP_DELETE, 16'h1234);
      add_cmd(OP_POP_BACK, 16'h0000);

      // Random: rotate fill, churn at full, mixed search/delete, drain.
      made  = 0;
      phase = 0;
      while (made < RANDOM_ITEMS) begin
         phase_len = $urandom_range(60, 100);
         for (int i = 0; i < phase_len; i++) begin
            case (phase)
               0:       c = pick_cmd(90, 2, 3, 3);
               1:       c = pick_cmd(60, 5, 10, 22);
               2:       c = pick_cmd(35, 20, 20, 20);
               default: c = pick_cmd(8, 85, 3, 3);
            endcase
            add_cmd(c, pick_id());
         end
         made += phase_len;
         phase = (phase + 1) % 4;
      end

      // Hold reset, then release it once.
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait until every command is accepted and every result has come back.
      do @(posedge clock);
      while (cmd_queue.size() > 0 || have_staged || start || expected_views.size() > 0);
      // Let any stray late result show up.
      repeat (DRAIN_CYCLES) @(posedge clock);

      // a prediction still waiting here means its result never came out
      if (expected_views.size() > 0) begin
         $error("results missing: expected %0d more, got 0", expected_views.size());
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
